@@ design/sbsd_pkg.sv @@
// Shared types, constants and the sextet alphabet lookup for the scanner
// barcode sextet decoder. No dependencies.
`default_nettype none

package sbsd_pkg;

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [2:0] DATA_DOT  = 3'd3;
    localparam logic [2:0] END_DOT   = 3'd4;
    localparam logic [7:0] KEY_RESET = 8'h43;  // 'C'

    localparam int         PADDR_W     = 3;
    localparam logic [0:0] REG_XOR_KEY = 1'b0;

    typedef struct packed {
        logic [7:0] ch;
        logic       record_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       data_done;
        logic       bad_char;
    } t_out;

    typedef struct packed {
        logic       hit;
        logic [5:0] val;
    } t_sextet;

    // a..z -> 0..25, A..Z -> 26..51, 0..9 -> 52..61, '+' -> 62, '-' -> 63
    function automatic t_sextet sextet_lookup(input logic [7:0] c);
        t_sextet s;
        s.hit = 1'b1;
        s.val = 6'd0;
        if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2D) begin
            s.val = 6'd63;
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/scanner_barcode_sextet_decoder_core.sv @@
// Top level of the scanner barcode sextet decoder: decode logic, result
// bank and APB key register. Depends on sbsd_pkg.
`default_nettype none

// Each item carries a scanner character; decoded barcode bytes are emitted.
// Only dots are counted before the third dot; characters between the
// third and fourth dot are data, each mapped through a 64-symbol alphabet to
// a sextet. Every four sextets yield three bytes (MSB first), each XORed with
// the key register (APB offset 0x0, reset 0x43). The fourth dot flushes a
// partial group of r sextets as r-1 bytes and then a done result. A data
// character outside the alphabet yields one bad_char result and the record is
// dropped until the next item with record_start set. record_start clears all
// decode state before its character is handled. An item is decoded in the
// cycle it is accepted and its results (zero to three) land in a three-entry
// result bank that drains one result per cycle while i_out_ready is high.
// The input is held while results are pending; the next item is taken once
// the bank is empty or in the cycle its last result leaves.
module scanner_barcode_sextet_decoder_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // item input
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  sbsd_pkg::t_in             i_in,
    // result output
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output sbsd_pkg::t_out                  o_out,
    // APB configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [sbsd_pkg::PADDR_W-1:0]    paddr,
    input  wire  [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // decode state
    logic [2:0]  r_dots,  n_dots;
    logic [1:0]  r_cnt,   n_cnt;
    logic [17:0] r_acc,   n_acc;
    logic        r_fail,  n_fail;
    logic [7:0]  r_key;

    // result bank: slot 0 is presented, r_left holds pending count
    sbsd_pkg::t_out r_slot [3];
    sbsd_pkg::t_out n_slot [3];
    logic [1:0]     r_left;
    logic [1:0]     n_res;

    logic in_acc, out_acc;

    // effective state after record_start
    logic [2:0]        e_dots;
    logic [1:0]        e_cnt;
    logic [17:0]       e_acc;
    logic              e_fail;
    logic [23:0]       word;
    logic [1:0]        nbytes;
    sbsd_pkg::t_sextet lk;

    function automatic sbsd_pkg::t_out mk_byte(input logic [7:0] b, input logic [7:0] k);
        sbsd_pkg::t_out r;
        r            = '0;
        r.out_byte   = b ^ k;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    assign pready      = 1'b1;
    assign o_out_valid = (r_left != 2'd0);
    assign o_out       = r_slot[0];
    assign out_acc     = o_out_valid && i_out_ready;
    // take a new item once the bank is empty or its last result leaves now
    assign o_in_ready  = (r_left == 2'd0) || (r_left == 2'd1 && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        prdata = '0;
        if (paddr[sbsd_pkg::PADDR_W-1] == sbsd_pkg::REG_XOR_KEY) begin
            prdata = {24'd0, r_key};
        end
    end

    // single-pass decode of the incoming item
    always_comb begin
        e_dots = i_in.record_start ? 3'd0  : r_dots;
        e_cnt  = i_in.record_start ? 2'd0  : r_cnt;
        e_acc  = i_in.record_start ? 18'd0 : r_acc;
        e_fail = i_in.record_start ? 1'b0  : r_fail;
        n_dots = e_dots;
        n_cnt  = e_cnt;
        n_acc  = e_acc;
        n_fail = e_fail;
        n_res  = 2'd0;
        word   = '0;
        nbytes = 2'd0;
        lk     = sbsd_pkg::sextet_lookup(i_in.ch);
        for (int i = 0; i < 3; i++) begin
            n_slot[i] = '0;
        end

        if (!e_fail && e_dots < sbsd_pkg::END_DOT) begin
            if (i_in.ch == sbsd_pkg::DOT_CHAR) begin
                n_dots = 3'(e_dots + 3'd1);
                if (n_dots == sbsd_pkg::END_DOT) begin
                    // flush partial group, zero-padded on the right
                    unique case (e_cnt)
                        2'd2:    word = {e_acc[11:0], 12'd0};
                        2'd3:    word = {e_acc, 6'd0};
                        default: word = '0;
                    endcase
                    nbytes    = (e_cnt >= 2'd2) ? 2'(e_cnt - 2'd1) : 2'd0;
                    n_slot[0] = mk_byte(word[23:16], r_key);
                    n_slot[1] = mk_byte(word[15:8], r_key);
                    n_slot[nbytes]           = '0;
                    n_slot[nbytes].data_done = 1'b1;
                    n_res     = 2'(nbytes + 2'd1);
                    n_cnt     = 2'd0;
                    n_acc     = '0;
                end
            end else if (e_dots == sbsd_pkg::DATA_DOT) begin
                if (!lk.hit) begin
                    n_fail             = 1'b1;
                    n_slot[0].bad_char = 1'b1;
                    n_res              = 2'd1;
                end else if (e_cnt == 2'd3) begin
                    word      = {e_acc, lk.val};
                    n_slot[0] = mk_byte(word[23:16], r_key);
                    n_slot[1] = mk_byte(word[15:8], r_key);
                    n_slot[2] = mk_byte(word[7:0], r_key);
                    n_res     = 2'd3;
                    n_cnt     = 2'd0;
                    n_acc     = '0;
                end else begin
                    n_acc = {e_acc[11:0], lk.val};
                    n_cnt = 2'(e_cnt + 2'd1);
                end
            end
        end

        for (int i = 0; i < 3; i++) begin
            n_slot[i].run_last = (2'(i) == 2'(n_res - 2'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dots <= '0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_fail <= 1'b0;
            r_key  <= sbsd_pkg::KEY_RESET;
            r_left <= '0;
        end else begin
            if (psel && penable && pwrite &&
                paddr[sbsd_pkg::PADDR_W-1] == sbsd_pkg::REG_XOR_KEY) begin
                r_key <= pwdata[7:0];
            end
            if (in_acc) begin
                r_dots <= n_dots;
                r_cnt  <= n_cnt;
                r_acc  <= n_acc;
                r_fail <= n_fail;
                r_left <= n_res;
            end else if (out_acc) begin
                r_left <= 2'(r_left - 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end else if (out_acc) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    // each presented result is exactly one kind
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_out.byte_valid, o_out.data_done, o_out.bad_char}))
        else $error("result carries more or less than one kind");

    // results of an item other than its last keep the output busy
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.run_last) |=> o_out_valid)
        else $error("result bank emptied before run_last");

    // run_last exactly on the final pending result
    a_last_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.run_last == (r_left == 2'd1)))
        else $error("run_last out of step with pending count");

    // dot counter saturates at the closing dot
    a_dots_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dots <= sbsd_pkg::END_DOT)
        else $error("dot count past closing dot");

    // no item taken while earlier results would be overwritten
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_left == 2'd0 || (r_left == 2'd1 && out_acc)))
        else $error("item accepted over pending results");

endmodule

`default_nettype wire
